// ===== rtl/core/hsvled_pkg.sv =====
// ----------------------------------------------------------------------------
// hsvled_pkg
// Shared types and constants for the HSV to RGB LED drive pipeline.
// ----------------------------------------------------------------------------
package hsvled_pkg;

    localparam int unsigned CH_W   = 8;
    localparam int unsigned HUE_W  = 9;
    localparam int unsigned NUM_CH = 3;

    localparam logic [HUE_W-1:0] HUE_MAX     = 9'd359;
    localparam logic [5:0]       SECTOR_SPAN = 6'd60;
    localparam logic [CH_W-1:0]  FULL_SCALE  = 8'd255;
    // 60 * 255: the full-scale weight used by q and t
    localparam logic [13:0]      FULL_SPAN   = 14'd15300;

    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 8;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_BRIGHTNESS   = 2'd0,
        REG_GAMMA_ENABLE = 2'd1,
        REG_COMMON_ANODE = 2'd2
    } cfg_reg_t;

    typedef enum logic [2:0] {
        SECTOR_0 = 3'd0,
        SECTOR_1 = 3'd1,
        SECTOR_2 = 3'd2,
        SECTOR_3 = 3'd3,
        SECTOR_4 = 3'd4,
        SECTOR_5 = 3'd5
    } sector_t;

    localparam logic [7:0] GAMMA_ROM [256] = '{
        8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0,
        8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0,
        8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0,
        8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd1,
        8'd1, 8'd1, 8'd1, 8'd1, 8'd1, 8'd1, 8'd1, 8'd1,
        8'd1, 8'd1, 8'd1, 8'd1, 8'd1, 8'd1, 8'd2, 8'd2,
        8'd2, 8'd2, 8'd2, 8'd2, 8'd3, 8'd3, 8'd3, 8'd3,
        8'd3, 8'd4, 8'd4, 8'd4, 8'd4, 8'd5, 8'd5, 8'd5,
        8'd5, 8'd6, 8'd6, 8'd6, 8'd7, 8'd7, 8'd7, 8'd8,
        8'd8, 8'd9, 8'd9, 8'd10, 8'd10, 8'd10, 8'd11, 8'd11,
        8'd12, 8'd12, 8'd13, 8'd13, 8'd14, 8'd15, 8'd15, 8'd16,
        8'd16, 8'd17, 8'd18, 8'd19, 8'd19, 8'd20, 8'd21, 8'd22,
        8'd23, 8'd23, 8'd24, 8'd25, 8'd26, 8'd27, 8'd28, 8'd29,
        8'd30, 8'd31, 8'd32, 8'd33, 8'd34, 8'd35, 8'd36, 8'd37,
        8'd38, 8'd40, 8'd41, 8'd42, 8'd43, 8'd44, 8'd46, 8'd47,
        8'd48, 8'd50, 8'd51, 8'd52, 8'd54, 8'd55, 8'd56, 8'd58,
        8'd59, 8'd61, 8'd62, 8'd64, 8'd65, 8'd67, 8'd68, 8'd70,
        8'd71, 8'd73, 8'd74, 8'd76, 8'd78, 8'd79, 8'd81, 8'd83,
        8'd84, 8'd86, 8'd88, 8'd90, 8'd91, 8'd93, 8'd95, 8'd97,
        8'd99, 8'd100, 8'd102, 8'd104, 8'd106, 8'd108, 8'd110, 8'd112,
        8'd114, 8'd116, 8'd118, 8'd120, 8'd122, 8'd124, 8'd126, 8'd128,
        8'd130, 8'd132, 8'd134, 8'd136, 8'd138, 8'd141, 8'd143, 8'd145,
        8'd147, 8'd149, 8'd152, 8'd154, 8'd156, 8'd159, 8'd161, 8'd163,
        8'd166, 8'd168, 8'd170, 8'd173, 8'd175, 8'd178, 8'd180, 8'd183,
        8'd185, 8'd188, 8'd190, 8'd193, 8'd195, 8'd198, 8'd201, 8'd203,
        8'd206, 8'd209, 8'd211, 8'd214, 8'd217, 8'd220, 8'd222, 8'd225,
        8'd228, 8'd231, 8'd234, 8'd237, 8'd239, 8'd242, 8'd245, 8'd248,
        8'd251, 8'd254, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255,
        8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255,
        8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255,
        8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255,
        8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255
    };

endpackage

// ===== rtl/core/hsvled_cdiv.sv =====
// ----------------------------------------------------------------------------
// hsvled_cdiv
// Two-stage floor division by a constant: reciprocal estimate, then one
// remainder check that corrects the estimate by at most one.
// ----------------------------------------------------------------------------
module hsvled_cdiv
    import hsvled_pkg::*;
#(
    parameter int unsigned X_W   = 16,
    parameter int unsigned DIV   = 255,
    parameter int unsigned SHIFT = 16
)
(
    input  logic            clk,
    input  logic            en,
    input  logic [X_W-1:0]  x,
    output logic [CH_W-1:0] q
);

    localparam longint unsigned RECIP = (64'd1 << SHIFT) / DIV;
    localparam int unsigned     M_W   = $clog2(RECIP + 1);
    localparam int unsigned     P_W   = X_W + M_W;

    logic [P_W-1:0]  prod;
    logic [X_W-1:0]  x_reg;
    logic [CH_W-1:0] est_reg;
    logic [X_W-1:0]  rem;
    logic [CH_W-1:0] q_reg;
    logic [CH_W-1:0] q_next;

    // Truncated reciprocal never overshoots and is short by at most one
    assign prod = P_W'(x) * P_W'(RECIP);

    always_comb
    begin
        rem = x_reg - X_W'(X_W'(est_reg) * X_W'(DIV));
        if (rem >= X_W'(DIV))
        begin
            q_next = est_reg + 8'd1;
        end
        else
        begin
            q_next = est_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg   <= x;
            est_reg <= prod[SHIFT +: CH_W];
            q_reg   <= q_next;
        end
    end

    assign q = q_reg;

endmodule

// ===== rtl/core/hsv_to_rgb_led_drive.sv =====
// ----------------------------------------------------------------------------
// hsv_to_rgb_led_drive
// HSV pixel to RGB conversion with per-channel LED PWM drive levels.
// ----------------------------------------------------------------------------
// Input stream s_axis carries one HSV pixel per transaction; hue above 359
// is treated as 359. Output stream m_axis carries the raw RGB colour and the
// three drive levels (brightness scale, optional gamma, optional inversion).
// The configuration port writes brightness, gamma enable and common anode
// at any edge where cfg_wr_en is high; write it only while the pipe is empty.
// Nine register stages lie between an input transaction and its output
// valid; each holds at most one multiply or one constant-division step, so
// the clock sets the rate: one pixel is accepted every cycle unless stalled.
// All stages advance together: when the output holds an unaccepted result,
// s_axis_tready drops and every stage holds, so nothing is lost or repeated.
// Reset clears all valid bits and loads brightness 255, gamma and common
// anode off. Results leave in input order.
// ----------------------------------------------------------------------------
module hsv_to_rgb_led_drive
    import hsvled_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,

    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // [8:0] hue, [16:9] saturation, [24:17] value_level, [31:25] zero
    input  logic [31:0]           s_axis_tdata,

    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // [7:0] raw_red, [15:8] raw_green, [23:16] raw_blue,
    // [31:24] drive_red, [39:32] drive_green, [47:40] drive_blue
    output logic [47:0]           m_axis_tdata,

    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int unsigned NUM_STAGES = 9;

    // ---------------- configuration ----------------
    logic [CH_W-1:0] brightness_reg;
    logic            gamma_enable_reg;
    logic            common_anode_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            brightness_reg   <= FULL_SCALE;
            gamma_enable_reg <= 1'b0;
            common_anode_reg <= 1'b0;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                REG_BRIGHTNESS:   brightness_reg   <= cfg_data;
                REG_GAMMA_ENABLE: gamma_enable_reg <= cfg_data[0];
                REG_COMMON_ANODE: common_anode_reg <= cfg_data[0];
                default:          ;
            endcase
        end
    end

    // ---------------- pipeline control ----------------
    logic                  en;
    logic [NUM_STAGES:1]   vld_reg;

    assign en            = !vld_reg[NUM_STAGES] || m_axis_tready;
    assign s_axis_tready = en;
    assign m_axis_tvalid = vld_reg[NUM_STAGES];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[NUM_STAGES-1:1], s_axis_tvalid};
        end
    end

    // ---------------- stage 1: clamp hue, split into sector and offset ----------------
    logic [HUE_W-1:0] hue;
    logic [CH_W-1:0]  sat_in;
    logic [CH_W-1:0]  val_in;
    logic [HUE_W-1:0] hue_c;
    logic [HUE_W-1:0] sec_base;
    sector_t          sec_s;
    logic [HUE_W-1:0] f_wide;

    assign hue    = s_axis_tdata[8:0];
    assign sat_in = s_axis_tdata[16:9];
    assign val_in = s_axis_tdata[24:17];

    always_comb
    begin
        hue_c = (hue > HUE_MAX) ? HUE_MAX : hue;
        priority if (hue_c >= 9'd300)
        begin
            sec_s    = SECTOR_5;
            sec_base = 9'd300;
        end
        else if (hue_c >= 9'd240)
        begin
            sec_s    = SECTOR_4;
            sec_base = 9'd240;
        end
        else if (hue_c >= 9'd180)
        begin
            sec_s    = SECTOR_3;
            sec_base = 9'd180;
        end
        else if (hue_c >= 9'd120)
        begin
            sec_s    = SECTOR_2;
            sec_base = 9'd120;
        end
        else if (hue_c >= 9'd60)
        begin
            sec_s    = SECTOR_1;
            sec_base = 9'd60;
        end
        else
        begin
            sec_s    = SECTOR_0;
            sec_base = 9'd0;
        end
        f_wide = hue_c - sec_base;
    end

    sector_t         sec1_reg;
    logic [5:0]      f1_reg;
    logic [5:0]      fc1_reg;
    logic [CH_W-1:0] s1_reg;
    logic [CH_W-1:0] v1_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sec1_reg <= sec_s;
            f1_reg   <= f_wide[5:0];
            fc1_reg  <= SECTOR_SPAN - f_wide[5:0];
            s1_reg   <= sat_in;
            v1_reg   <= val_in;
        end
    end

    // ---------------- stage 2: saturation products ----------------
    sector_t         sec2_reg;
    logic [13:0]     sf2_reg;
    logic [13:0]     sfc2_reg;
    logic [15:0]     pn2_reg;
    logic [CH_W-1:0] v2_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sec2_reg <= sec1_reg;
            sf2_reg  <= 14'(s1_reg) * 14'(f1_reg);
            sfc2_reg <= 14'(s1_reg) * 14'(fc1_reg);
            pn2_reg  <= 16'(v1_reg) * 16'(FULL_SCALE - s1_reg);
            v2_reg   <= v1_reg;
        end
    end

    // ---------------- stage 3: numerators of q and t ----------------
    sector_t         sec3_reg;
    logic [21:0]     qn3_reg;
    logic [21:0]     tn3_reg;
    logic [15:0]     pn3_reg;
    logic [CH_W-1:0] v3_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sec3_reg <= sec2_reg;
            qn3_reg  <= 22'(v2_reg) * 22'(FULL_SPAN - sf2_reg);
            tn3_reg  <= 22'(v2_reg) * 22'(FULL_SPAN - sfc2_reg);
            pn3_reg  <= pn2_reg;
            v3_reg   <= v2_reg;
        end
    end

    // ---------------- stages 4-5: constant divisions for p, q, t ----------------
    logic [CH_W-1:0] p5;
    logic [CH_W-1:0] q5;
    logic [CH_W-1:0] t5;

    hsvled_cdiv #(.X_W(16), .DIV(255), .SHIFT(16)) u_div_p
    (
        .clk (clk),
        .en  (en),
        .x   (pn3_reg),
        .q   (p5)
    );

    hsvled_cdiv #(.X_W(22), .DIV(15300), .SHIFT(22)) u_div_q
    (
        .clk (clk),
        .en  (en),
        .x   (qn3_reg),
        .q   (q5)
    );

    hsvled_cdiv #(.X_W(22), .DIV(15300), .SHIFT(22)) u_div_t
    (
        .clk (clk),
        .en  (en),
        .x   (tn3_reg),
        .q   (t5)
    );

    sector_t         sec4_reg;
    sector_t         sec5_reg;
    logic [CH_W-1:0] v4_reg;
    logic [CH_W-1:0] v5_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sec4_reg <= sec3_reg;
            sec5_reg <= sec4_reg;
            v4_reg   <= v3_reg;
            v5_reg   <= v4_reg;
        end
    end

    // ---------------- stage 6: place channels, scale by brightness ----------------
    logic [CH_W-1:0] rgb [NUM_CH];

    always_comb
    begin
        unique case (sec5_reg)
            SECTOR_0:
            begin
                rgb[0] = v5_reg; rgb[1] = t5;     rgb[2] = p5;
            end
            SECTOR_1:
            begin
                rgb[0] = q5;     rgb[1] = v5_reg; rgb[2] = p5;
            end
            SECTOR_2:
            begin
                rgb[0] = p5;     rgb[1] = v5_reg; rgb[2] = t5;
            end
            SECTOR_3:
            begin
                rgb[0] = p5;     rgb[1] = q5;     rgb[2] = v5_reg;
            end
            SECTOR_4:
            begin
                rgb[0] = t5;     rgb[1] = p5;     rgb[2] = v5_reg;
            end
            default:
            begin
                rgb[0] = v5_reg; rgb[1] = p5;     rgb[2] = q5;
            end
        endcase
    end

    logic [CH_W-1:0] raw6_reg  [NUM_CH];
    logic [15:0]     prod6_reg [NUM_CH];
    logic [CH_W-1:0] raw7_reg  [NUM_CH];
    logic [CH_W-1:0] raw8_reg  [NUM_CH];
    logic [CH_W-1:0] raw9_reg  [NUM_CH];
    logic [CH_W-1:0] lvl8      [NUM_CH];
    logic [CH_W-1:0] drv9_reg  [NUM_CH];

    // ---------------- stages 7-8: divide by 255; stage 9: gamma, invert ----------------
    for (genvar c = 0; c < NUM_CH; c++)
    begin : g_ch
        logic [CH_W-1:0] gam;

        hsvled_cdiv #(.X_W(16), .DIV(255), .SHIFT(16)) u_div_drv
        (
            .clk (clk),
            .en  (en),
            .x   (prod6_reg[c]),
            .q   (lvl8[c])
        );

        assign gam = gamma_enable_reg ? GAMMA_ROM[lvl8[c]] : lvl8[c];

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                raw6_reg[c]  <= rgb[c];
                prod6_reg[c] <= 16'(rgb[c]) * 16'(brightness_reg);
                raw7_reg[c]  <= raw6_reg[c];
                raw8_reg[c]  <= raw7_reg[c];
                raw9_reg[c]  <= raw8_reg[c];
                drv9_reg[c]  <= common_anode_reg ? (FULL_SCALE - gam) : gam;
            end
        end
    end

    assign m_axis_tdata = {drv9_reg[2], drv9_reg[1], drv9_reg[0],
                           raw9_reg[2], raw9_reg[1], raw9_reg[0]};

    // ---------------- assertions ----------------
    a_ready_follows_output: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tready == (!m_axis_tvalid || m_axis_tready))
        else $error("input ready does not track output stall");

    a_accept_enters_pipe: assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready) |=> vld_reg[1])
        else $error("accepted transaction missing from first stage");

    a_result_leaves_on_accept: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(m_axis_tvalid) |-> $past(m_axis_tready))
        else $error("result dropped without being taken");

endmodule
